>>> rtl/sts_pkg.sv
`timescale 1ns / 1ps

package sts_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 10;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                     opcode;
    logic                     restart;
    logic signed [ValueW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] index;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    append;
    logic    rd_en;
    logic    step;
    logic    load_res;
    status_e res_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic range_empty;
    logic hit;
  } dp_sts_t;

endpackage

>>> rtl/sts_ctrl.sv
`timescale 1ns / 1ps

module sts_ctrl
  import sts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_opcode_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_PROBE,
    S_CMP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // a result may be loaded when the output register is empty or drains this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_NOTFOUND;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = (in_opcode_i == OP_SEARCH) ? S_PROBE : S_APPEND;
        end
      end
      S_APPEND: begin
        if (slot_free) begin
          cmd_o.append     = 1'b1;
          cmd_o.load_res   = 1'b1;
          cmd_o.res_status = sts_i.full ? ST_FULL : ST_APPENDED;
          state_d = S_IDLE;
        end
      end
      S_PROBE: begin
        if (sts_i.range_empty) begin
          if (slot_free) begin
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = ST_NOTFOUND;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.hit) begin
          if (slot_free) begin
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = ST_FOUND;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_PROBE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_res) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // a pending result must never be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_res |-> slot_free)
    else $error("result loaded over a stalled beat");

  // a probe read is always followed by its compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> state_q == S_CMP)
    else $error("probe read not followed by compare");

  // a stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("result beat dropped while stalled");

endmodule

>>> rtl/sts_dp.sv
`timescale 1ns / 1ps

module sts_dp
  import sts_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_beat_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [ValueW-1:0] mem_q [DEPTH];

  logic [CW-1:0]            count_q;
  logic                     restart_q;
  logic signed [ValueW-1:0] target_q;
  // closed interval [left, hi - 1]
  logic [CW-1:0]            left_q;
  logic [CW-1:0]            hi_q;
  logic [AW-1:0]            mid_q;
  logic signed [ValueW-1:0] rdata_q;
  out_beat_t                res_q;

  logic [CW-1:0] base;
  logic          full;
  logic [CW-1:0] span;
  logic [CW-1:0] mid_full;
  logic [AW-1:0] mid_d;
  logic [31:0]   base_ext;
  logic [31:0]   mid_ext;

  assign base = restart_q ? '0 : count_q;
  assign full = (base == CW'(DEPTH));

  // mid = left + (right - left) / 2 with right = hi - 1
  assign span     = hi_q - left_q - CW'(1);
  assign mid_full = left_q + (span >> 1);
  assign mid_d    = mid_full[AW-1:0];

  assign base_ext = 32'(base);
  assign mid_ext  = 32'(mid_q);

  assign sts_o.full        = full;
  assign sts_o.range_empty = (left_q >= hi_q);
  assign sts_o.hit         = (rdata_q == target_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem_q[base[AW-1:0]] <= target_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[mid_d];
      mid_q   <= mid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.append && !full) begin
      count_q <= base + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      restart_q <= in_data_i.restart;
      target_q  <= in_data_i.value;
      left_q    <= '0;
      hi_q      <= count_q;
    end else if (cmd_i.step) begin
      if (rdata_q < target_q) begin
        left_q <= CW'(mid_q) + CW'(1);
      end else begin
        hi_q <= CW'(mid_q);
      end
    end
    if (cmd_i.load_res) begin
      res_q.status <= cmd_i.res_status;
      unique case (cmd_i.res_status)
        ST_APPENDED: res_q.index <= base_ext[IndexW-1:0];
        ST_FOUND:    res_q.index <= mid_ext[IndexW-1:0];
        default:     res_q.index <= '0;
      endcase
    end
  end

  assign out_data_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // only loaded entries are ever probed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |=> CW'(mid_q) < count_q)
    else $error("probe outside loaded entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (left_q < hi_q) && (hi_q <= count_q))
    else $error("probe with an empty or stale interval");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append && !full |=> count_q == $past(base) + CW'(1))
    else $error("append did not advance the entry count");

endmodule

>>> rtl/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// channel | signals                          | beat
// in      | in_valid_i, in_stall_o, in_data_i    | opcode, restart, value
// out     | out_valid_o, out_stall_i, out_data_o | status, index
//
// one item at a time; an append writes the table and loads its result once the output register is free
// a search probes until a hit or until the interval is empty, at most log2(DEPTH) + 1 probes,
// each probe being one registered table read and one compare
// reset empties the table at once; table contents are not cleared
// a new item is accepted while a finished result still waits on out_stall_i

module sorted_table_binary_search
  import sts_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> sim/sorted_table_binary_search_checker.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_checker
  import sts_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_beat_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_beat_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic signed [ValueW-1:0] entries [DEPTH];
  int unsigned entry_count;
  out_beat_t   awaited [$];
  int unsigned fails;
  int unsigned pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // updates the shadow table and returns the result the block must give
  function automatic out_beat_t search_or_append(in_beat_t b);
    out_beat_t                r;
    logic signed [ValueW-1:0] key;
    int                       lo;
    int                       hi;
    int                       mid;
    r   = '0;
    key = b.value;
    if (b.opcode == OP_APPEND) begin
      if (b.restart) entry_count = 0;
      if (entry_count < DEPTH) begin
        entries[entry_count] = key;
        r.status = ST_APPENDED;
        r.index  = entry_count[IndexW-1:0];
        entry_count++;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      r.status = ST_NOTFOUND;
      lo = 0;
      hi = int'(entry_count) - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (entries[mid] == key) begin
          r.status = ST_FOUND;
          r.index  = mid[IndexW-1:0];
          break;
        end
        if (entries[mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      entry_count = 0;
      awaited.delete();
      fails   = 0;
      pending = 0;
    end else begin
      // result beat first: it always belongs to an earlier input beat
      if (out_valid_i && !out_stall_i) begin
        if (awaited.size() == 0) begin
          $display("%0t: result with none expected, status %0d index %0d", $time,
                   out_data_i.status, out_data_i.index);
          fails++;
        end else begin
          want = awaited.pop_front();
          if (want.status !== out_data_i.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data_i.status);
            fails++;
          end
          if (want.index !== out_data_i.index) begin
            $display("%0t: index expected %0d got %0d", $time, want.index,
                     out_data_i.index);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) awaited.push_back(search_or_append(in_data_i));
      pending = awaited.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import sts_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned ItemGoal    = 1350;
  localparam int unsigned DrainCycles = 40;
  localparam logic signed [ValueW-1:0] MinVal = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] MaxVal = 32'sh7FFF_FFFF;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int unsigned fails;
  int unsigned pending;

  // copy of what was loaded, only used to pick search targets
  logic signed [ValueW-1:0] loaded [DEPTH];
  int unsigned loaded_count = 0;
  int unsigned sent         = 0;
  int unsigned burst_left   = 0;

  int unsigned stall_run = 0;
  int unsigned stall_pct = 0;
  int unsigned cyc       = 0;

  sorted_table_binary_search #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  sorted_table_binary_search_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls in runs; the stall density changes now and then
  always @(negedge clk) begin
    if (cyc % 600 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    cyc++;
    if (stall_run == 0) begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_run = $urandom_range(1, 10);
    end
    stall_run--;
  end

  // called and returns right after a falling edge
  task automatic send(input logic op, input logic rs, input logic signed [ValueW-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_data  <= {op, rs, v};
    in_valid <= 1'b1;
    if (op == OP_APPEND) begin
      if (rs) loaded_count = 0;
      if (loaded_count < DEPTH) begin
        loaded[loaded_count] = v;
        loaded_count++;
      end
    end
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  // restart and load k ascending values, sometimes with runs of duplicates
  task automatic load_sorted(input int unsigned k);
    longint lo;
    longint hi;
    longint cur;
    longint step_max;
    int     base;
    bit     end_at_max;
    base = $urandom;
    hi   = longint'(MaxVal);
    lo   = ($urandom_range(0, 3) == 0) ? longint'(MinVal) : longint'(base);
    end_at_max = ($urandom_range(0, 3) == 0);
    step_max   = ($urandom_range(0, 3) == 0) ? 2 : (hi - lo) / k;
    cur = lo;
    for (int unsigned i = 0; i < k; i++) begin
      if (end_at_max && i == k - 1) cur = hi;
      send(OP_APPEND, i == 0, cur[ValueW-1:0]);
      cur += $urandom_range(0, 32'(step_max));
      if (cur > hi) cur = hi;
    end
  endtask

  // mostly present values, some neighbors and extremes
  task automatic probe_table(input int unsigned n);
    int unsigned              pick;
    int unsigned              idx;
    logic signed [ValueW-1:0] t;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      t    = $urandom;
      if (loaded_count != 0) begin
        idx = $urandom_range(0, loaded_count - 1);
        if (pick < 6) t = loaded[idx];
        else if (pick == 6) t = loaded[idx] + 1;
        else if (pick == 7) t = loaded[idx] - 1;
        else if (pick == 8) t = $urandom_range(0, 1) ? MinVal : MaxVal;
      end
      send(OP_SEARCH, 1'($urandom_range(0, 1)), t);
    end
  endtask

  task automatic noise(input int unsigned n);
    logic signed [ValueW-1:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      v = $urandom;
      if (loaded_count != 0 && $urandom_range(0, 2) == 0)
        v = loaded[$urandom_range(0, loaded_count - 1)];
      send(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, v);
    end
  endtask

  initial begin
    int unsigned full_at;
    bit          full_done;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, restart ignored on search
    send(OP_SEARCH, 1'b0, 32'sd0);
    send(OP_SEARCH, 1'b1, -32'sd1);
    // sorted table spanning the whole range
    send(OP_APPEND, 1'b1, MinVal);
    send(OP_APPEND, 1'b0, -32'sd1);
    send(OP_APPEND, 1'b0, 32'sd0);
    send(OP_APPEND, 1'b0, 32'sd2);
    send(OP_APPEND, 1'b0, MaxVal);
    send(OP_SEARCH, 1'b0, MinVal);
    send(OP_SEARCH, 1'b0, MaxVal);
    send(OP_SEARCH, 1'b1, 32'sd2);
    send(OP_SEARCH, 1'b0, 32'sd1);
    send(OP_SEARCH, 1'b0, MaxVal - 1);
    // unsorted table: 1 is hit at the first midpoint, 3 is missed
    send(OP_APPEND, 1'b1, 32'sd5);
    send(OP_APPEND, 1'b0, 32'sd1);
    send(OP_APPEND, 1'b0, 32'sd9);
    send(OP_APPEND, 1'b0, 32'sd3);
    send(OP_SEARCH, 1'b0, 32'sd1);
    send(OP_SEARCH, 1'b0, 32'sd3);
    // restart drops the old contents
    send(OP_APPEND, 1'b1, 32'sd7);
    send(OP_SEARCH, 1'b0, 32'sd5);
    send(OP_SEARCH, 1'b0, 32'sd7);

    full_done = 1'b0;
    full_at   = $urandom_range(100, 250);
    while (sent < ItemGoal) begin
      if (!full_done && sent >= full_at) begin
        // fill to the brim, overflow, then search the full table
        load_sorted(DEPTH);
        repeat (3) send(OP_APPEND, 1'b0, $urandom);
        probe_table(25);
        full_done = 1'b1;
      end else begin
        if ($urandom_range(0, 9) < 8) begin
          load_sorted($urandom_range(1, 40));
          probe_table($urandom_range(1, 12));
        end else begin
          noise($urandom_range(1, 15));
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fails == 0) begin
      $display("[sorted_table_binary_search] OK");
    end else begin
      $display("[sorted_table_binary_search] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[sorted_table_binary_search] ERROR");
    $finish;
  end

endmodule
